>>> hdl/complex_arithmetic_unit_top_defines.svh
// ----------------------------------------------------------------------------
// complex arithmetic unit assertion macros
// shared property wrappers for the concurrent checks of the unit
// ----------------------------------------------------------------------------
`ifndef COMPLEX_ARITHMETIC_UNIT_TOP_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_TOP_DEFINES_SVH

// same-cycle implication under reset
`define CAU_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under reset
`define CAU_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/cau_pkg.sv
// ----------------------------------------------------------------------------
// complex arithmetic unit package
// operation codes and the control bundle of the divider pipeline
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam logic [3:0] OP_ADD  = 4'd0;
    localparam logic [3:0] OP_SUB  = 4'd1;
    localparam logic [3:0] OP_MUL  = 4'd2;
    localparam logic [3:0] OP_DIV  = 4'd3;
    localparam logic [3:0] OP_CONJ = 4'd4;
    localparam logic [3:0] OP_NEG  = 4'd5;
    localparam logic [3:0] OP_NORM = 4'd6;
    localparam logic [3:0] OP_SCL  = 4'd7;
    localparam logic [3:0] OP_RDIV = 4'd8;

    // per-item control carried alongside the quotient lanes
    typedef struct packed {
        logic valid;
        logic is_div;
        logic dz;
        logic neg_re;
        logic neg_im;
        logic big_re;
        logic big_im;
    } t_div_ctrl;

endpackage

>>> hdl/cau_in_if.sv
// ----------------------------------------------------------------------------
// complex arithmetic unit operand channel
// valid/ready channel carrying one operation and two complex operands
// ----------------------------------------------------------------------------
interface cau_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  operation;
    logic signed [31:0] a_re;
    logic signed [31:0] a_im;
    logic signed [31:0] b_re;
    logic signed [31:0] b_im;

    modport source (output valid, operation, a_re, a_im, b_re, b_im, input ready);
    modport sink   (input valid, operation, a_re, a_im, b_re, b_im, output ready);
endinterface

>>> hdl/cau_out_if.sv
// ----------------------------------------------------------------------------
// complex arithmetic unit result channel
// valid/ready channel carrying one complex result and its flags
// ----------------------------------------------------------------------------
interface cau_out_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] r_re;
    logic signed [31:0] r_im;
    logic        overflow;
    logic        div_zero;

    modport source (output valid, r_re, r_im, overflow, div_zero, input ready);
    modport sink   (input valid, r_re, r_im, overflow, div_zero, output ready);
endinterface

>>> hdl/cau_div_pipe.sv
// ----------------------------------------------------------------------------
// complex arithmetic unit divider pipeline
// two restoring divider lanes sharing one divisor, one quotient bit per stage
// ----------------------------------------------------------------------------
module cau_div_pipe
    import cau_pkg::*;
#(
    parameter int STEPS = 33
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  t_div_ctrl          i_ctrl,
    input  logic [63:0]        i_d,
    input  logic [63:0]        i_rem_re,
    input  logic [STEPS-1:0]   i_nq_re,
    input  logic [63:0]        i_rem_im,
    input  logic [STEPS-1:0]   i_nq_im,
    output t_div_ctrl          o_ctrl,
    output logic [STEPS-1:0]   o_nq_re,
    output logic [STEPS-1:0]   o_nq_im
);

    t_div_ctrl          r_ctrl   [0:STEPS-1];
    logic [63:0]        r_d      [0:STEPS-1];
    logic [63:0]        r_rem_re [0:STEPS-1];
    logic [63:0]        r_rem_im [0:STEPS-1];
    logic [STEPS-1:0]   r_nq_re  [0:STEPS-1];
    logic [STEPS-1:0]   r_nq_im  [0:STEPS-1];

    for (genvar g = 0; g < STEPS; g++) begin : g_step
        t_div_ctrl        w_ctrl;
        logic [63:0]      w_d;
        logic [63:0]      w_rem_re;
        logic [63:0]      w_rem_im;
        logic [STEPS-1:0] w_nq_re;
        logic [STEPS-1:0] w_nq_im;
        logic [64:0]      w_t_re;
        logic [64:0]      w_t_im;
        logic             w_ge_re;
        logic             w_ge_im;
        logic [63:0]      n_rem_re;
        logic [63:0]      n_rem_im;
        logic [STEPS-1:0] n_nq_re;
        logic [STEPS-1:0] n_nq_im;

        // stage input: operands or previous stage
        if (g == 0) begin : g_first
            assign w_ctrl   = i_ctrl;
            assign w_d      = i_d;
            assign w_rem_re = i_rem_re;
            assign w_rem_im = i_rem_im;
            assign w_nq_re  = i_nq_re;
            assign w_nq_im  = i_nq_im;
        end else begin : g_next
            assign w_ctrl   = r_ctrl[g-1];
            assign w_d      = r_d[g-1];
            assign w_rem_re = r_rem_re[g-1];
            assign w_rem_im = r_rem_im[g-1];
            assign w_nq_re  = r_nq_re[g-1];
            assign w_nq_im  = r_nq_im[g-1];
        end

        // shift in the next dividend bit, trial subtract
        always_comb begin
            w_t_re   = {w_rem_re, w_nq_re[STEPS-1]};
            w_t_im   = {w_rem_im, w_nq_im[STEPS-1]};
            w_ge_re  = w_t_re >= {1'b0, w_d};
            w_ge_im  = w_t_im >= {1'b0, w_d};
            n_rem_re = w_rem_re;
            n_rem_im = w_rem_im;
            n_nq_re  = w_nq_re;
            n_nq_im  = w_nq_im;
            if (w_ctrl.is_div) begin
                n_rem_re = w_ge_re ? 64'(w_t_re - {1'b0, w_d}) : w_t_re[63:0];
                n_rem_im = w_ge_im ? 64'(w_t_im - {1'b0, w_d}) : w_t_im[63:0];
                n_nq_re  = {w_nq_re[STEPS-2:0], w_ge_re};
                n_nq_im  = {w_nq_im[STEPS-2:0], w_ge_im};
            end
        end

        // stage control
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctrl[g] <= '0;
            end else if (i_en) begin
                r_ctrl[g] <= w_ctrl;
            end
        end

        // stage data
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_d[g]      <= w_d;
                r_rem_re[g] <= n_rem_re;
                r_rem_im[g] <= n_rem_im;
                r_nq_re[g]  <= n_nq_re;
                r_nq_im[g]  <= n_nq_im;
            end
        end
    end

    assign o_ctrl  = r_ctrl[STEPS-1];
    assign o_nq_re = r_nq_re[STEPS-1];
    assign o_nq_im = r_nq_im[STEPS-1];

endmodule

>>> hdl/complex_arithmetic_unit_top.sv
// ----------------------------------------------------------------------------
// complex arithmetic unit
// pipelined complex alu over signed fixed point with saturation flags
// ----------------------------------------------------------------------------
//  channel   dir  fields                                    transfer
//  i_in      in   operation, a_re, a_im, b_re, b_im         valid & ready
//  o_out     out  r_re, r_im, overflow, div_zero            valid & ready
//
//  one item per cycle while the output is not stalled; the stages are operand,
//  multiply, sum, magnitude, prepare, WORD_BITS + 1 divider steps and output
//  register, the restoring divider retiring one quotient bit per stage
//  every item passes the full depth, whatever its operation
//  a stalled output freezes the whole pipeline; ready follows the output slot
//  reset clears the valid bits and the divider control bundles only
// ----------------------------------------------------------------------------
`include "complex_arithmetic_unit_top_defines.svh"

module complex_arithmetic_unit_top
    import cau_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int WORD_BITS = 32
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    cau_in_if.sink   i_in,
    cau_out_if.source o_out
);

    localparam int IW = (WORD_BITS < 32) ? WORD_BITS : 32;
    localparam int QB = WORD_BITS + 1;
    localparam int NW = 64 + FRAC_BITS;
    localparam int HW = NW - QB;
    localparam int CW = (HW > 64) ? HW : 64;

    logic w_en;

    // global advance: output slot empty or draining
    assign w_en       = !o_out.valid || o_out.ready;
    assign i_in.ready = w_en;

    // ---------------- stage a: operand register ----------------
    logic               r_a_valid;
    logic [3:0]         r_a_op;
    logic signed [32:0] r_a_ar, r_a_ai, r_a_br, r_a_bi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_en) begin
            r_a_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_op <= i_in.operation;
            r_a_ar <= 33'($signed(i_in.a_re[IW-1:0]));
            r_a_ai <= 33'($signed(i_in.a_im[IW-1:0]));
            r_a_br <= 33'($signed(i_in.b_re[IW-1:0]));
            r_a_bi <= 33'($signed(i_in.b_im[IW-1:0]));
        end
    end

    // ---------------- stage b: products ----------------
    logic               r_b_valid;
    logic [3:0]         r_b_op;
    logic signed [32:0] r_b_ar, r_b_ai, r_b_br, r_b_bi;
    logic signed [65:0] r_b_p0, r_b_p1, r_b_p2, r_b_p3, r_b_p4, r_b_p5;
    logic signed [32:0] w_y0, w_y1;

    // norm squares a, everything else multiplies by b
    assign w_y0 = (r_a_op == OP_NORM) ? r_a_ar : r_a_br;
    assign w_y1 = (r_a_op == OP_NORM) ? r_a_ai : r_a_bi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_op <= r_a_op;
            r_b_ar <= r_a_ar;
            r_b_ai <= r_a_ai;
            r_b_br <= r_a_br;
            r_b_bi <= r_a_bi;
            r_b_p0 <= r_a_ar * w_y0;
            r_b_p1 <= r_a_ai * w_y1;
            r_b_p2 <= r_a_ar * r_a_bi;
            r_b_p3 <= r_a_ai * r_a_br;
            r_b_p4 <= r_a_br * r_a_br;
            r_b_p5 <= r_a_bi * r_a_bi;
        end
    end

    // ---------------- stage c: sums per operation ----------------
    logic               r_c_valid, r_c_round, r_c_div, r_c_dz;
    logic signed [66:0] r_c_re, r_c_im, r_c_den;
    logic signed [66:0] n_c_re, n_c_im, n_c_den;
    logic               n_c_round, n_c_div, n_c_dz;

    always_comb begin
        n_c_re    = '0;
        n_c_im    = '0;
        n_c_den   = '0;
        n_c_round = 1'b0;
        n_c_div   = 1'b0;
        n_c_dz    = 1'b0;
        unique case (r_b_op)
            OP_ADD: begin
                n_c_re = 67'(r_b_ar) + 67'(r_b_br);
                n_c_im = 67'(r_b_ai) + 67'(r_b_bi);
            end
            OP_SUB: begin
                n_c_re = 67'(r_b_ar) - 67'(r_b_br);
                n_c_im = 67'(r_b_ai) - 67'(r_b_bi);
            end
            OP_MUL: begin
                n_c_re    = 67'(r_b_p0) - 67'(r_b_p1);
                n_c_im    = 67'(r_b_p2) + 67'(r_b_p3);
                n_c_round = 1'b1;
            end
            OP_DIV: begin
                n_c_dz  = (r_b_br == '0) && (r_b_bi == '0);
                n_c_den = 67'(r_b_p4) + 67'(r_b_p5);
                if (n_c_dz) begin
                    n_c_re = 67'(r_b_ar);
                    n_c_im = 67'(r_b_ai);
                end else begin
                    n_c_re  = 67'(r_b_p0) + 67'(r_b_p1);
                    n_c_im  = 67'(r_b_p3) - 67'(r_b_p2);
                    n_c_div = 1'b1;
                end
            end
            OP_CONJ: begin
                n_c_re = 67'(r_b_ar);
                n_c_im = -67'(r_b_ai);
            end
            OP_NEG: begin
                n_c_re = -67'(r_b_ar);
                n_c_im = -67'(r_b_ai);
            end
            OP_NORM: begin
                n_c_re    = 67'(r_b_p0) + 67'(r_b_p1);
                n_c_round = 1'b1;
            end
            OP_SCL: begin
                n_c_re    = 67'(r_b_p0);
                n_c_im    = 67'(r_b_p3);
                n_c_round = 1'b1;
            end
            OP_RDIV: begin
                n_c_re  = 67'(r_b_ar);
                n_c_im  = 67'(r_b_ai);
                n_c_den = 67'(r_b_br);
                n_c_dz  = (r_b_br == '0);
                n_c_div = !n_c_dz;
            end
            default: begin
                n_c_re = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (w_en) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_re    <= n_c_re;
            r_c_im    <= n_c_im;
            r_c_den   <= n_c_den;
            r_c_round <= n_c_round;
            r_c_div   <= n_c_div;
            r_c_dz    <= n_c_dz;
        end
    end

    // ---------------- stage d: sign and magnitude ----------------
    logic        r_d_valid, r_d_round, r_d_div, r_d_dz;
    logic        r_d_neg_re, r_d_neg_im, r_d_neg_den;
    logic [63:0] r_d_mag_re, r_d_mag_im, r_d_mag_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (w_en) begin
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d_round   <= r_c_round;
            r_d_div     <= r_c_div;
            r_d_dz      <= r_c_dz;
            r_d_neg_re  <= r_c_re[66];
            r_d_neg_im  <= r_c_im[66];
            r_d_neg_den <= r_c_den[66];
            r_d_mag_re  <= r_c_re[66] ? 64'(-r_c_re) : r_c_re[63:0];
            r_d_mag_im  <= r_c_im[66] ? 64'(-r_c_im) : r_c_im[63:0];
            r_d_mag_den <= r_c_den[66] ? 64'(-r_c_den) : r_c_den[63:0];
        end
    end

    // ---------------- stage e: round, clamp or divider setup ----------------
    t_div_ctrl        r_e_ctrl, n_e_ctrl;
    logic [63:0]      r_e_d;
    logic [63:0]      r_e_rem_re, r_e_rem_im, n_e_rem_re, n_e_rem_im;
    logic [QB-1:0]    r_e_nq_re, r_e_nq_im, n_e_nq_re, n_e_nq_im;
    logic [NW-1:0]    w_n_re, w_n_im;
    logic [HW-1:0]    w_hi_re, w_hi_im;
    logic [63:0]      w_v_re, w_v_im;

    always_comb begin
        w_n_re  = {r_d_mag_re, {FRAC_BITS{1'b0}}};
        w_n_im  = {r_d_mag_im, {FRAC_BITS{1'b0}}};
        w_hi_re = w_n_re[NW-1:QB];
        w_hi_im = w_n_im[NW-1:QB];
        // product rounding, half away from zero
        if (r_d_round) begin
            w_v_re = (r_d_mag_re >> FRAC_BITS) + 64'(r_d_mag_re[FRAC_BITS-1]);
            w_v_im = (r_d_mag_im >> FRAC_BITS) + 64'(r_d_mag_im[FRAC_BITS-1]);
        end else begin
            w_v_re = r_d_mag_re;
            w_v_im = r_d_mag_im;
        end

        n_e_ctrl.valid  = r_d_valid;
        n_e_ctrl.is_div = r_d_div;
        n_e_ctrl.dz     = r_d_dz;
        n_e_rem_re      = 64'(w_hi_re);
        n_e_rem_im      = 64'(w_hi_im);
        priority if (r_d_dz) begin
            // zero divisor: saturate toward the sign of a
            n_e_ctrl.neg_re = r_d_neg_re;
            n_e_ctrl.neg_im = r_d_neg_im;
            n_e_ctrl.big_re = (r_d_mag_re != '0);
            n_e_ctrl.big_im = (r_d_mag_im != '0);
            n_e_nq_re       = '0;
            n_e_nq_im       = '0;
        end else if (r_d_div) begin
            // quotient too large when the top of the dividend reaches the divisor
            n_e_ctrl.neg_re = r_d_neg_re ^ r_d_neg_den;
            n_e_ctrl.neg_im = r_d_neg_im ^ r_d_neg_den;
            n_e_ctrl.big_re = CW'(w_hi_re) >= CW'(r_d_mag_den);
            n_e_ctrl.big_im = CW'(w_hi_im) >= CW'(r_d_mag_den);
            n_e_nq_re       = w_n_re[QB-1:0];
            n_e_nq_im       = w_n_im[QB-1:0];
        end else begin
            n_e_ctrl.neg_re = r_d_neg_re;
            n_e_ctrl.neg_im = r_d_neg_im;
            n_e_ctrl.big_re = |w_v_re[63:QB];
            n_e_ctrl.big_im = |w_v_im[63:QB];
            n_e_nq_re       = w_v_re[QB-1:0];
            n_e_nq_im       = w_v_im[QB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_ctrl <= '0;
        end else if (w_en) begin
            r_e_ctrl <= n_e_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e_d      <= r_d_mag_den;
            r_e_rem_re <= n_e_rem_re;
            r_e_rem_im <= n_e_rem_im;
            r_e_nq_re  <= n_e_nq_re;
            r_e_nq_im  <= n_e_nq_im;
        end
    end

    // ---------------- divider steps ----------------
    t_div_ctrl     w_q_ctrl;
    logic [QB-1:0] w_q_re, w_q_im;

    cau_div_pipe #(
        .STEPS (QB)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_ctrl   (r_e_ctrl),
        .i_d      (r_e_d),
        .i_rem_re (r_e_rem_re),
        .i_nq_re  (r_e_nq_re),
        .i_rem_im (r_e_rem_im),
        .i_nq_im  (r_e_nq_im),
        .o_ctrl   (w_q_ctrl),
        .o_nq_re  (w_q_re),
        .o_nq_im  (w_q_im)
    );

    // ---------------- output stage: saturation ----------------
    logic [QB-1:0]    w_lim_re, w_lim_im, w_m_re, w_m_im;
    logic             w_sat_re, w_sat_im;
    logic signed [QB:0] w_s_re, w_s_im;

    always_comb begin
        w_lim_re = w_q_ctrl.neg_re ? (QB'(1) << (WORD_BITS - 1))
                                   : (QB'(1) << (WORD_BITS - 1)) - QB'(1);
        w_lim_im = w_q_ctrl.neg_im ? (QB'(1) << (WORD_BITS - 1))
                                   : (QB'(1) << (WORD_BITS - 1)) - QB'(1);
        w_sat_re = w_q_ctrl.big_re || (w_q_re > w_lim_re);
        w_sat_im = w_q_ctrl.big_im || (w_q_im > w_lim_im);
        w_m_re   = w_sat_re ? w_lim_re : w_q_re;
        w_m_im   = w_sat_im ? w_lim_im : w_q_im;
        w_s_re   = w_q_ctrl.neg_re ? -$signed({1'b0, w_m_re}) : $signed({1'b0, w_m_re});
        w_s_im   = w_q_ctrl.neg_im ? -$signed({1'b0, w_m_im}) : $signed({1'b0, w_m_im});
    end

    logic               r_o_valid, r_o_ovf, r_o_dz;
    logic signed [31:0] r_o_re, r_o_im;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_en) begin
            r_o_valid <= w_q_ctrl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_re  <= 32'(w_s_re);
            r_o_im  <= 32'(w_s_im);
            r_o_ovf <= w_sat_re || w_sat_im;
            r_o_dz  <= w_q_ctrl.dz;
        end
    end

    assign o_out.valid    = r_o_valid;
    assign o_out.r_re     = r_o_re;
    assign o_out.r_im     = r_o_im;
    assign o_out.overflow = r_o_ovf;
    assign o_out.div_zero = r_o_dz;

    // ---------------- checks ----------------
    `CAU_ASSERT_NOW(a_dz_result, i_clk, i_rst_n, o_out.valid && o_out.div_zero, o_out.overflow || (o_out.r_re == '0 && o_out.r_im == '0), "zero divisor result neither saturated nor zero")
    `CAU_ASSERT_NOW(a_div_excl, i_clk, i_rst_n, r_e_ctrl.valid && r_e_ctrl.dz, !r_e_ctrl.is_div, "zero divisor item routed through the divider")
    `CAU_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, !w_en, $stable(r_e_ctrl) && $stable(r_a_valid), "pipeline moved during a stall")

endmodule
